/* sv/nkm_pkg.sv */
// Shared types and codes for the neighbor keepalive monitor.
package nkm_pkg;

    localparam int MAC_W  = 48;
    localparam int TICK_W = 32;

    // input kinds
    localparam logic [2:0] K_TICK      = 3'd0;
    localparam logic [2:0] K_TRACK     = 3'd1;
    localparam logic [2:0] K_UNTRACK   = 3'd2;
    localparam logic [2:0] K_BEACON    = 3'd3;
    localparam logic [2:0] K_UNREACH   = 3'd4;
    localparam logic [2:0] K_REACH     = 3'd5;

    // message kinds
    localparam logic [2:0] M_SUMMARY    = 3'd0;
    localparam logic [2:0] M_BEACON     = 3'd1;
    localparam logic [2:0] M_UNREACH    = 3'd2;
    localparam logic [2:0] M_CHILD_REP  = 3'd3;
    localparam logic [2:0] M_TIMED_OUT  = 3'd4;
    localparam logic [2:0] M_DISCONNECT = 3'd5;

    // roles
    localparam logic [1:0] ROLE_PARENT = 2'd1;
    localparam logic [1:0] ROLE_CHILD  = 2'd2;

    // root reachability codes
    localparam logic [1:0] RR_NONE    = 2'd0;
    localparam logic [1:0] RR_LOST    = 2'd1;
    localparam logic [1:0] RR_REGAIN  = 2'd2;

    // register indexes
    localparam logic [1:0] R_BEACON_INT = 2'd0;
    localparam logic [1:0] R_NB_TIMEOUT = 2'd1;
    localparam logic [1:0] R_ROOT_TMO   = 2'd2;
    localparam logic [1:0] R_IS_ROOT    = 2'd3;

    localparam int OUT_LIMIT = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_BCAST_RD,
        ST_BCAST,
        ST_PARENT_DISC,
        ST_CHILD_REP,
        ST_ROOT_RD,
        ST_ROOT,
        ST_ROOT_DISC,
        ST_BEACON_RD,
        ST_BEACON,
        ST_NEXT_RD,
        ST_NEXT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [MAC_W-1:0]  dest;
        logic [MAC_W-1:0]  subj;
        logic              to_root;
        logic [1:0]        reach;
        logic              full;
        logic [TICK_W-1:0] next_in;
        logic              last;
    } msg_t;

    // ticks left of a limit, floored at zero
    function automatic logic [TICK_W-1:0] remaining(input logic [TICK_W-1:0] now,
                                                    input logic [TICK_W-1:0] since,
                                                    input logic [TICK_W-1:0] limit);
        logic [TICK_W-1:0] el;
        begin
            el = now - since;
            remaining = (el < limit) ? (limit - el) : '0;
        end
    endfunction

endpackage

/* sv/nkm_out_reg.sv */
// Output register stage for result transfers.
module nkm_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nkm_pkg::msg_t in_msg,
    output logic          out_valid,
    input  logic          out_ready,
    output nkm_pkg::msg_t out_msg
);
    import nkm_pkg::*;

    logic valid_reg;
    msg_t msg_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_msg   = msg_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            msg_reg <= in_msg;
    end
endmodule

/* sv/neighbor_keepalive_monitor_core.sv */
// Top level of the neighbor keepalive monitor.
// Usage:
//  s_axis carries one event per transfer: kind, now, neighbor_mac, role,
//  node_connected. m_axis returns the messages caused by the event, the
//  summary (msg_kind 0) last with tlast high.
//  Entries live in a table memory with registered reads; the sequencer
//  walks the table once per pass: a free entry is skipped in the read
//  state, a tracked entry goes through the read state and a work state,
//  and the read state closes the pass. Non-tick events: lookup pass and
//  next-action pass. Ticks: timeout pass, root check, beacon pass and
//  next-action pass; a firing root timeout adds a parent search and a
//  disconnect, and a timed-out entry may add a child report, or a
//  parent-loss broadcast and a disconnect. One event is in work at a
//  time; the next is taken once the summary has entered the output
//  register. Reset clears all valid bits and timers; the registers take
//  their defaults. Configuration writes go through cfg_we/cfg_addr/cfg_wdata.
//  When m_axis_tready is low the sequencer waits on the message it holds;
//  no message is dropped by a stall. At most 31 messages precede a summary.
module neighbor_keepalive_monitor_core #(
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] now, [79:32] neighbor_mac, [81:80] neighbor_role,
    // [82] node_connected, [87:83] zero
    input  logic [87:0]  s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] dest_mac, [95:48] subject_mac, [96] to_root,
    // [98:97] root_reachable, [99] table_full, [131:100] next_action_in,
    // [135:132] zero
    output logic [135:0] m_axis_tdata,
    // [2:0] msg_kind
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import nkm_pkg::*;

    localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW = $clog2(MAX_NEIGHBORS + 1);
    localparam int EW = MAC_W + 2 + TICK_W;

    // configuration registers
    logic [31:0] beacon_int_reg, nb_timeout_reg, root_tmo_reg;
    logic        is_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beacon_int_reg <= 32'd300;
            nb_timeout_reg <= 32'd3000;
            root_tmo_reg   <= 32'd10000;
            is_root_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                R_BEACON_INT: beacon_int_reg <= cfg_wdata;
                R_NB_TIMEOUT: nb_timeout_reg <= cfg_wdata;
                R_ROOT_TMO:   root_tmo_reg   <= cfg_wdata;
                R_IS_ROOT:    is_root_reg    <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // entry memory: {mac, role, last_seen}
    logic [EW-1:0] mem [MAX_NEIGHBORS];
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [EW-1:0] wr_data, rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    wire [MAC_W-1:0]  rd_mac  = rd_data_reg[EW-1 -: MAC_W];
    wire [1:0]        rd_role = rd_data_reg[TICK_W +: 2];
    wire [TICK_W-1:0] rd_seen = rd_data_reg[TICK_W-1:0];

    // control and state registers
    state_t state_reg, state_next;
    logic [MAX_NEIGHBORS-1:0] valid_reg, valid_next;
    logic [CW-1:0] idx_reg, idx_next;     // walks entries
    logic [CW-1:0] sub_reg, sub_next;     // broadcast walk
    logic [1:0] hrole_reg, hrole_next;    // stored role of the matched entry
    logic [MAC_W-1:0] hmac_reg, hmac_next;
    logic [5:0] cnt_reg, cnt_next;        // messages emitted
    logic [TICK_W-1:0] best_reg, best_next;
    logic [TICK_W-1:0] last_beacon_reg, last_beacon_next;
    logic [TICK_W-1:0] since_reg, since_next;
    logic awaiting_reg, awaiting_next;
    logic [1:0] reach_reg, reach_next;
    logic full_reg, full_next;
    logic found_reg, found_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic free_ok_reg, free_ok_next;
    logic [IW-1:0] free_reg, free_next;

    // latched input item
    logic [2:0]        kind_reg;
    logic [TICK_W-1:0] now_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [1:0]        role_reg;
    logic              conn_reg;

    logic msg_valid, msg_ready;
    msg_t msg, out_msg;

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    wire [IW-1:0] idx = idx_reg[IW-1:0];
    wire [IW-1:0] sub = sub_reg[IW-1:0];
    wire idx_end = (idx_reg == CW'(MAX_NEIGHBORS));
    wire sub_end = (sub_reg == CW'(MAX_NEIGHBORS));
    wire room = (cnt_reg < 6'(OUT_LIMIT - 1));

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        idx_next         = idx_reg;
        sub_next         = sub_reg;
        hrole_next       = hrole_reg;
        hmac_next        = hmac_reg;
        cnt_next         = cnt_reg;
        best_next        = best_reg;
        last_beacon_next = last_beacon_reg;
        since_next       = since_reg;
        awaiting_next    = awaiting_reg;
        reach_next       = reach_reg;
        full_next        = full_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        free_ok_next     = free_ok_reg;
        free_next        = free_reg;
        rd_addr          = idx;
        wr_en            = 1'b0;
        wr_addr          = slot_reg;
        wr_data          = {mac_reg, role_reg, now_reg};
        msg_valid        = 1'b0;
        msg              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next   = '0;
                cnt_next   = '0;
                reach_next = RR_NONE;
                full_next  = 1'b0;
                found_next = 1'b0;
                free_ok_next = 1'b0;
                if (accept)
                    state_next = ST_SCAN_RD;
            end

            // issue read of entry idx
            ST_SCAN_RD:
            begin
                if (idx_end)
                begin
                    if (kind_reg == K_TICK)
                    begin
                        idx_next   = '0;
                        state_next = ST_ROOT_RD;
                    end
                    else
                    begin
                        // apply non-tick event
                        case (kind_reg)
                            K_TRACK:
                            begin
                                if (found_reg || free_ok_reg)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = found_reg ? slot_reg : free_reg;
                                    valid_next[found_reg ? slot_reg : free_reg] = 1'b1;
                                end
                                else
                                    full_next = 1'b1;
                            end
                            K_UNTRACK:
                                if (found_reg) valid_next[slot_reg] = 1'b0;
                            K_BEACON:
                            begin
                                if (found_reg)
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = {hmac_reg, hrole_reg, now_reg};
                                end
                            end
                            K_UNREACH:
                            begin
                                if (!is_root_reg && conn_reg && !awaiting_reg)
                                begin
                                    since_next    = now_reg;
                                    awaiting_next = 1'b1;
                                    reach_next    = RR_LOST;
                                end
                            end
                            K_REACH:
                            begin
                                if (!is_root_reg && conn_reg && awaiting_reg)
                                begin
                                    since_next    = '0;
                                    awaiting_next = 1'b0;
                                    reach_next    = RR_REGAIN;
                                end
                            end
                            default: ;
                        endcase
                        idx_next   = '0;
                        state_next = ST_NEXT_RD;
                    end
                end
                else if (!valid_reg[idx])
                begin
                    if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                    state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (kind_reg == K_TICK)
                begin
                    if ((now_reg - rd_seen) > nb_timeout_reg)
                    begin
                        valid_next[idx] = 1'b0;
                        hmac_next = rd_mac;
                        msg_valid = room;
                        msg.kind  = M_TIMED_OUT;
                        msg.dest  = rd_mac;
                        if (msg_ready || !room)
                        begin
                            if (room) cnt_next = cnt_reg + 1'b1;
                            idx_next = idx_reg + 1'b1;
                            if (rd_role == ROLE_PARENT)
                            begin
                                sub_next   = '0;
                                state_next = ST_BCAST_RD;
                            end
                            else if (rd_role == ROLE_CHILD && !is_root_reg)
                                state_next = ST_CHILD_REP;
                            else
                                state_next = ST_SCAN_RD;
                        end
                        else
                            valid_next[idx] = 1'b1; // retry next cycle
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
                else
                begin
                    if (!found_reg && rd_mac == mac_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = idx;
                        hmac_next  = rd_mac;
                        hrole_next = rd_role;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_CHILD_REP:
            begin
                msg_valid    = room;
                msg.kind     = M_CHILD_REP;
                msg.subj     = hmac_reg;
                msg.to_root  = 1'b1;
                if (msg_ready || !room)
                begin
                    if (room) cnt_next = cnt_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            // mesh unreachable to every remaining valid entry
            ST_BCAST_RD:
            begin
                rd_addr = sub;
                if (sub_end)
                    state_next = ST_PARENT_DISC;
                else if (!valid_reg[sub])
                    sub_next = sub_reg + 1'b1;
                else
                    state_next = ST_BCAST;
            end

            ST_BCAST:
            begin
                rd_addr   = sub;
                msg_valid = room;
                msg.kind  = M_UNREACH;
                msg.dest  = rd_mac;
                if (msg_ready || !room)
                begin
                    if (room) cnt_next = cnt_reg + 1'b1;
                    sub_next   = sub_reg + 1'b1;
                    state_next = ST_BCAST_RD;
                end
            end

            ST_PARENT_DISC:
            begin
                msg_valid = room;
                msg.kind  = M_DISCONNECT;
                msg.dest  = hmac_reg;
                if (msg_ready || !room)
                begin
                    if (room) cnt_next = cnt_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            // root timeout: find first parent
            ST_ROOT_RD:
            begin
                if (!(awaiting_reg && (now_reg - since_reg) > root_tmo_reg))
                begin
                    idx_next   = '0;
                    state_next = ST_BEACON_RD;
                end
                else if (idx_end)
                begin
                    hmac_next  = '0;
                    state_next = ST_ROOT_DISC;
                end
                else if (!valid_reg[idx])
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_ROOT;
            end

            ST_ROOT:
            begin
                if (rd_role == ROLE_PARENT)
                begin
                    valid_next[idx] = 1'b0;
                    hmac_next       = rd_mac;
                    state_next      = ST_ROOT_DISC;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ROOT_RD;
                end
            end

            ST_ROOT_DISC:
            begin
                msg_valid = room;
                msg.kind  = M_DISCONNECT;
                msg.dest  = hmac_reg;
                if (msg_ready || !room)
                begin
                    if (room) cnt_next = cnt_reg + 1'b1;
                    awaiting_next = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_BEACON_RD;
                end
            end

            // beacon round
            ST_BEACON_RD:
            begin
                if (!((now_reg - last_beacon_reg) >= beacon_int_reg) || valid_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = ST_NEXT_RD;
                end
                else if (idx_end)
                begin
                    last_beacon_next = now_reg;
                    idx_next         = '0;
                    state_next       = ST_NEXT_RD;
                end
                else if (!valid_reg[idx])
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_BEACON;
            end

            ST_BEACON:
            begin
                msg_valid = room;
                msg.kind  = M_BEACON;
                msg.dest  = rd_mac;
                if (msg_ready || !room)
                begin
                    if (room) cnt_next = cnt_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_BEACON_RD;
                end
            end

            // next action minimum
            ST_NEXT_RD:
            begin
                if (idx_reg == '0)
                    best_next = remaining(now_reg, last_beacon_reg, beacon_int_reg);
                if (idx_end)
                begin
                    if (awaiting_reg &&
                        remaining(now_reg, since_reg, root_tmo_reg) < best_reg)
                        best_next = remaining(now_reg, since_reg, root_tmo_reg);
                    if (valid_reg == '0)
                        best_next = '1;
                    state_next = ST_SUMMARY;
                end
                else if (!valid_reg[idx])
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                if (remaining(now_reg, rd_seen, nb_timeout_reg) < best_reg)
                    best_next = remaining(now_reg, rd_seen, nb_timeout_reg);
                idx_next   = idx_reg + 1'b1;
                state_next = ST_NEXT_RD;
            end

            ST_SUMMARY:
            begin
                msg_valid    = 1'b1;
                msg.kind     = M_SUMMARY;
                msg.reach    = reach_reg;
                msg.full     = full_reg;
                msg.next_in  = best_reg;
                msg.last     = 1'b1;
                if (msg_ready)
                    state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            idx_reg         <= '0;
            sub_reg         <= '0;
            cnt_reg         <= '0;
            last_beacon_reg <= '0;
            since_reg       <= '0;
            awaiting_reg    <= 1'b0;
            reach_reg       <= RR_NONE;
            full_reg        <= 1'b0;
            found_reg       <= 1'b0;
            free_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            idx_reg         <= idx_next;
            sub_reg         <= sub_next;
            cnt_reg         <= cnt_next;
            last_beacon_reg <= last_beacon_next;
            since_reg       <= since_next;
            awaiting_reg    <= awaiting_next;
            reach_reg       <= reach_next;
            full_reg        <= full_next;
            found_reg       <= found_next;
            free_ok_reg     <= free_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hrole_reg <= hrole_next;
        hmac_reg  <= hmac_next;
        best_reg  <= best_next;
        slot_reg  <= slot_next;
        free_reg  <= free_next;
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            now_reg  <= s_axis_tdata[31:0];
            mac_reg  <= s_axis_tdata[79:32];
            role_reg <= s_axis_tdata[81:80];
            conn_reg <= s_axis_tdata[82];
        end
    end

    nkm_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg_valid),
        .in_ready  (msg_ready),
        .in_msg    (msg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_msg   (out_msg)
    );

    assign m_axis_tuser = out_msg.kind;
    assign m_axis_tlast = out_msg.last;
    assign m_axis_tdata = {4'b0, out_msg.next_in, out_msg.full, out_msg.reach,
                           out_msg.to_root, out_msg.subj, out_msg.dest};
endmodule

/* sv/nkm_checker.sv */
// Port-level checks for the neighbor keepalive monitor, bound to the top level.
module nkm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import nkm_pkg::*;

    // one event in work at a time: input closes right after a transfer
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // tlast marks summaries and only them
    a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == M_SUMMARY)))
        else $error("tlast does not match summary");

    // only a summary carries reachability, fullness or next action
    a_side_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[131:97] == '0)
        else $error("non-summary result carries summary fields");

    // to_root only on a child report
    a_to_root: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tuser == M_CHILD_REP)
        else $error("to_root on wrong message");
endmodule

bind neighbor_keepalive_monitor_core nkm_checker u_nkm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* dv/tb_neighbor_keepalive_monitor_core.sv */
// Self-checking testbench for the neighbor keepalive monitor core.
module tb_neighbor_keepalive_monitor_core;
    import nkm_pkg::*;

    localparam int NB = 8;
    localparam int CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    neighbor_keepalive_monitor_core #(.MAX_NEIGHBORS(NB)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the block's registers and table
    logic [31:0]       sh_beacon_int;
    logic [31:0]       sh_nb_timeout;
    logic [31:0]       sh_root_tmo;
    logic              sh_is_root;
    logic              tbl_valid [NB];
    logic [MAC_W-1:0]  tbl_mac   [NB];
    logic [1:0]        tbl_role  [NB];
    logic [31:0]       tbl_seen  [NB];
    logic [31:0]       last_beacon;
    logic              awaiting;
    logic [31:0]       unreach_since;

    msg_t   expected_msgs[$];
    msg_t   step_msgs[$];
    int     errors;
    int     cycles;
    int     items_sent;
    int     msgs_checked;
    bit     quiet_phase;
    bit     stall_enable;
    logic [31:0] cur_now;
    logic [MAC_W-1:0] mac_pool[6];

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output stall, with a quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= quiet_phase || !stall_enable ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        msg_t act;
        msg_t exp_m;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act.kind    = m_axis_tuser;
            act.dest    = m_axis_tdata[47:0];
            act.subj    = m_axis_tdata[95:48];
            act.to_root = m_axis_tdata[96];
            act.reach   = m_axis_tdata[98:97];
            act.full    = m_axis_tdata[99];
            act.next_in = m_axis_tdata[131:100];
            act.last    = m_axis_tlast;
            msgs_checked++;
            if (expected_msgs.size() == 0)
            begin
                $error("unexpected message kind %0d", act.kind);
                errors++;
            end
            else
            begin
                exp_m = expected_msgs.pop_front();
                if (act.kind != exp_m.kind)
                begin
                    $error("msg_kind exp %0d got %0d", exp_m.kind, act.kind); errors++;
                end
                if (act.dest != exp_m.dest)
                begin
                    $error("dest_mac exp %h got %h", exp_m.dest, act.dest); errors++;
                end
                if (act.subj != exp_m.subj)
                begin
                    $error("subject_mac exp %h got %h", exp_m.subj, act.subj); errors++;
                end
                if (act.to_root != exp_m.to_root)
                begin
                    $error("to_root exp %0d got %0d", exp_m.to_root, act.to_root); errors++;
                end
                if (act.reach != exp_m.reach)
                begin
                    $error("root_reachable exp %0d got %0d", exp_m.reach, act.reach); errors++;
                end
                if (act.full != exp_m.full)
                begin
                    $error("table_full exp %0d got %0d", exp_m.full, act.full); errors++;
                end
                if (act.next_in != exp_m.next_in)
                begin
                    $error("next_action_in exp %0d got %0d", exp_m.next_in, act.next_in); errors++;
                end
                if (act.last != exp_m.last)
                begin
                    $error("last exp %0d got %0d", exp_m.last, act.last); errors++;
                end
            end
        end
    end

    function automatic logic [31:0] ticks_left(logic [31:0] now, logic [31:0] since,
                                               logic [31:0] lim);
        logic [31:0] el;
        el = now - since;
        return (el < lim) ? lim - el : 32'd0;
    endfunction

    function automatic bit table_nonempty();
        bit any;
        any = 0;
        for (int i = 0; i < NB; i++)
            if (tbl_valid[i]) any = 1;
        return any;
    endfunction

    function automatic int lookup_mac(logic [MAC_W-1:0] mac);
        for (int i = 0; i < NB; i++)
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        return -1;
    endfunction

    // queue one message for the step, dropping anything past the output cap
    task automatic add_msg(logic [2:0] kind, logic [MAC_W-1:0] dest,
                           logic [MAC_W-1:0] subj, logic to_root);
        msg_t m;
        if (step_msgs.size() >= OUT_LIMIT - 1) return;
        m = '0;
        m.kind = kind;
        m.dest = dest;
        m.subj = subj;
        m.to_root = to_root;
        step_msgs.push_back(m);
    endtask

    // tick processing: timeouts, root timeout, beacon round
    task automatic run_tick(logic [31:0] now);
        logic [MAC_W-1:0] pmac;
        for (int i = 0; i < NB; i++)
        begin
            if (!tbl_valid[i] || (now - tbl_seen[i]) <= sh_nb_timeout) continue;
            tbl_valid[i] = 1'b0;
            add_msg(M_TIMED_OUT, tbl_mac[i], '0, 1'b0);
            if (tbl_role[i] == ROLE_PARENT)
            begin
                for (int j = 0; j < NB; j++)
                    if (tbl_valid[j]) add_msg(M_UNREACH, tbl_mac[j], '0, 1'b0);
                add_msg(M_DISCONNECT, tbl_mac[i], '0, 1'b0);
            end
            else if (tbl_role[i] == ROLE_CHILD && !sh_is_root)
                add_msg(M_CHILD_REP, '0, tbl_mac[i], 1'b1);
        end
        if (awaiting && (now - unreach_since) > sh_root_tmo)
        begin
            awaiting = 1'b0;
            pmac = '0;
            for (int i = 0; i < NB; i++)
                if (tbl_valid[i] && tbl_role[i] == ROLE_PARENT)
                begin
                    tbl_valid[i] = 1'b0;
                    pmac = tbl_mac[i];
                    break;
                end
            add_msg(M_DISCONNECT, pmac, '0, 1'b0);
        end
        if ((now - last_beacon) >= sh_beacon_int && table_nonempty())
        begin
            for (int i = 0; i < NB; i++)
                if (tbl_valid[i]) add_msg(M_BEACON, tbl_mac[i], '0, 1'b0);
            last_beacon = now;
        end
    endtask

    // predict all messages of one event and append them to the expectations
    task automatic predict_event(logic [2:0] kind, logic [31:0] now, logic [MAC_W-1:0] mac,
                                 logic [1:0] role, logic conn);
        logic [1:0] reach;
        logic       full;
        logic [31:0] best;
        int k;
        msg_t s;
        reach = RR_NONE;
        full = 1'b0;
        step_msgs.delete();
        case (kind)
            K_TICK: run_tick(now);
            K_TRACK:
            begin
                k = lookup_mac(mac);
                if (k < 0)
                    for (int i = 0; i < NB; i++)
                        if (!tbl_valid[i])
                        begin
                            k = i;
                            break;
                        end
                if (k < 0)
                    full = 1'b1;
                else
                begin
                    tbl_valid[k] = 1'b1;
                    tbl_mac[k] = mac;
                    tbl_role[k] = role;
                    tbl_seen[k] = now;
                end
            end
            K_UNTRACK:
            begin
                k = lookup_mac(mac);
                if (k >= 0) tbl_valid[k] = 1'b0;
            end
            K_BEACON:
            begin
                k = lookup_mac(mac);
                if (k >= 0) tbl_seen[k] = now;
            end
            K_UNREACH:
                if (!sh_is_root && conn && !awaiting)
                begin
                    unreach_since = now;
                    awaiting = 1'b1;
                    reach = RR_LOST;
                end
            K_REACH:
                if (!sh_is_root && conn && awaiting)
                begin
                    unreach_since = '0;
                    awaiting = 1'b0;
                    reach = RR_REGAIN;
                end
            default: ;
        endcase
        // next due action
        if (!table_nonempty())
            best = '1;
        else
        begin
            best = ticks_left(now, last_beacon, sh_beacon_int);
            for (int i = 0; i < NB; i++)
                if (tbl_valid[i] && ticks_left(now, tbl_seen[i], sh_nb_timeout) < best)
                    best = ticks_left(now, tbl_seen[i], sh_nb_timeout);
            if (awaiting && ticks_left(now, unreach_since, sh_root_tmo) < best)
                best = ticks_left(now, unreach_since, sh_root_tmo);
        end
        s = '0;
        s.kind = M_SUMMARY;
        s.reach = reach;
        s.full = full;
        s.next_in = best;
        s.last = 1'b1;
        step_msgs.push_back(s);
        foreach (step_msgs[i]) expected_msgs.push_back(step_msgs[i]);
    endtask

    // send one event and hold it until the transfer
    task automatic send_event(logic [2:0] kind, logic [31:0] now, logic [MAC_W-1:0] mac,
                              logic [1:0] role, logic conn);
        while (stall_enable && !quiet_phase && $urandom_range(99) < 18)
            @(posedge clk);
        predict_event(kind, now, mac, role, conn);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, conn, role, mac, now};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        s_axis_tvalid <= 1'b0;
        items_sent++;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            R_BEACON_INT: sh_beacon_int = val;
            R_NB_TIMEOUT: sh_nb_timeout = val;
            R_ROOT_TMO:   sh_root_tmo = val;
            default:      sh_is_root = val[0];
        endcase
    endtask

    task automatic step_time(int lo, int hi);
        cur_now = cur_now + $urandom_range(hi, lo);
    endtask

    // directed: field extremes, all kinds, full table, parent loss, root timeout
    task automatic test_directed();
        send_event(K_TICK, 32'd0, '0, 2'd0, 1'b0);
        send_event(K_TRACK, 32'd5, 48'hFFFF_FFFF_FFFF, ROLE_PARENT, 1'b1);
        for (int i = 0; i < NB; i++)
            send_event(K_TRACK, 32'd10 + i, 48'h0 + i, 2'(i % 4), 1'b0);
        send_event(K_BEACON, 32'd100, 48'h3, 2'd3, 1'b1);
        send_event(K_BEACON, 32'd100, 48'h1234, 2'd0, 1'b0);
        send_event(K_UNREACH, 32'd200, '0, 2'd0, 1'b0);
        send_event(K_UNREACH, 32'd200, '0, 2'd0, 1'b1);
        send_event(K_UNREACH, 32'd201, '0, 2'd0, 1'b1);
        send_event(K_TICK, 32'd400, '0, 2'd0, 1'b0);
        send_event(K_REACH, 32'd500, '0, 2'd0, 1'b1);
        send_event(K_REACH, 32'd501, '0, 2'd0, 1'b1);
        send_event(K_UNTRACK, 32'd600, 48'h7, 2'd0, 1'b0);
        send_event(K_UNTRACK, 32'd600, 48'h99, 2'd0, 1'b0);
        send_event(3'd6, 32'd700, 48'h5, 2'd1, 1'b1);
        send_event(3'd7, 32'd700, 48'h5, 2'd2, 1'b1);
        send_event(K_UNREACH, 32'd800, '0, 2'd0, 1'b1);
        // everything times out: parent broadcast, child reports, root timeout
        send_event(K_TICK, 32'hFFFF_FFF0, '0, 2'd0, 1'b0);
        send_event(K_TICK, 32'hFFFF_FFFF, '0, 2'd0, 1'b1);
    endtask

    // random events, mostly on a small pool of addresses with time moving forward
    task automatic test_random(int count);
        logic [2:0] kind;
        logic [MAC_W-1:0] mac;
        int r;
        for (int n = 0; n < count; n++)
        begin
            quiet_phase = (n >= count / 3 && n < count / 3 + 40);
            r = $urandom_range(99);
            if (r < 40)      kind = K_TICK;
            else if (r < 60) kind = K_TRACK;
            else if (r < 68) kind = K_UNTRACK;
            else if (r < 84) kind = K_BEACON;
            else if (r < 91) kind = K_UNREACH;
            else if (r < 98) kind = K_REACH;
            else             kind = 3'($urandom_range(7, 6));
            mac = ($urandom_range(9) == 0) ? MAC_W'({$urandom, $urandom})
                                           : mac_pool[$urandom_range(5)];
            if ($urandom_range(49) == 0)
                cur_now = $urandom;
            else
                step_time(0, 3 * sh_nb_timeout / 2);
            send_event(kind, cur_now, mac, 2'($urandom_range(3)), 1'($urandom_range(9) != 0));
            // sender backs off until the block is empty
            if (n % 97 == 50)
                while (expected_msgs.size() != 0) @(posedge clk);
        end
        quiet_phase = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        msgs_checked = 0;
        quiet_phase = 0;
        stall_enable = 1;
        cur_now = 0;
        sh_beacon_int = 32'd300;
        sh_nb_timeout = 32'd3000;
        sh_root_tmo = 32'd10000;
        sh_is_root = 1'b0;
        last_beacon = '0;
        awaiting = 1'b0;
        unreach_since = '0;
        for (int i = 0; i < NB; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i] = '0;
            tbl_role[i] = '0;
            tbl_seen[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            mac_pool[i] = MAC_W'({$urandom, $urandom});
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(R_BEACON_INT, 32'd50);
        write_reg(R_NB_TIMEOUT, 32'd400);
        write_reg(R_ROOT_TMO, 32'd900);
        test_random(150);
        write_reg(R_IS_ROOT, 32'd1);
        write_reg(R_BEACON_INT, 32'd1);
        write_reg(R_NB_TIMEOUT, 32'd1);
        write_reg(R_ROOT_TMO, 32'd1);
        test_random(60);
        write_reg(R_IS_ROOT, 32'd0);
        write_reg(R_BEACON_INT, 32'hFFFF_FFFF);
        write_reg(R_NB_TIMEOUT, 32'd2000);
        write_reg(R_ROOT_TMO, 32'd3000);
        test_random(100);
        write_reg(R_NB_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(R_ROOT_TMO, 32'hFFFF_FFFF);
        write_reg(R_BEACON_INT, 32'd700);
        test_random(60);

        wait_drained();
        $display("Ran %0d events through all kinds and register extremes, %0d messages checked.",
                 items_sent, msgs_checked);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/nkm_pkg.sv
sv/nkm_out_reg.sv
sv/neighbor_keepalive_monitor_core.sv
sv/nkm_checker.sv
dv/tb_neighbor_keepalive_monitor_core.sv
